// ===== rtl/xmcr_pkg.sv =====
// Shared types and constants for the XMODEM checksum receiver.
`timescale 1ns / 1ps

package xmcr_pkg;

	// Event codes on the input channel
	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_BYTE    = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// Protocol control bytes
	localparam logic [7:0] C_SOH = 8'h01;
	localparam logic [7:0] C_EOT = 8'h04;
	localparam logic [7:0] C_ACK = 8'h06;
	localparam logic [7:0] C_NAK = 8'h15;
	localparam logic [7:0] C_CAN = 8'h18;

	// Status codes
	localparam logic [2:0] ST_RUN      = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_RCANCEL  = 3'd2;
	localparam logic [2:0] ST_HEADER   = 3'd3;
	localparam logic [2:0] ST_CHECKSUM = 3'd4;
	localparam logic [2:0] ST_OOM      = 3'd5;
	localparam logic [2:0] ST_RXERR    = 3'd6;

	// Configuration register indexes and reset values
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE    = 1'd1;
	localparam logic [7:0]  RETRY_LIMIT_RST = 8'd16;
	localparam logic [23:0] MAX_SIZE_RST    = 24'd16777088;

	typedef struct packed {
		logic                 en;
		logic [CFG_IDX_W-1:0] index;
		logic [23:0]          data;
	} cfg_wr_t;

	typedef struct packed {
		logic        mem_write;
		logic [23:0] mem_addr;
		logic [7:0]  mem_data;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic [2:0]  status;
		logic [24:0] byte_count;
	} result_t;

endpackage

// ===== rtl/xmcr_if.sv =====
// Channel interfaces: event input, result output and configuration writes.
`timescale 1ns / 1ps

interface xmcr_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface xmcr_res_if;
	logic        valid;
	logic        ready;
	logic        mem_write;
	logic [23:0] mem_addr;
	logic [7:0]  mem_data;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic [2:0]  status;
	logic [24:0] byte_count;

	modport source (output valid, output mem_write, output mem_addr, output mem_data,
		output tx_valid, output tx_byte, output status, output byte_count, input ready);
	modport sink (input valid, input mem_write, input mem_addr, input mem_data,
		input tx_valid, input tx_byte, input status, input byte_count, output ready);
endinterface

interface xmcr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [xmcr_pkg::CFG_IDX_W-1:0]     index;
	logic [23:0]                        data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/xmcr_core.sv =====
// Protocol state registers, configuration registers and per-item next-state logic.
`timescale 1ns / 1ps

module xmcr_core #(
	parameter int unsigned PACKET_BYTES = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          operation,
	input  logic [7:0]          rx_byte,
	input  xmcr_pkg::cfg_wr_t   cfg_wr,
	output xmcr_pkg::result_t   result
);

	localparam int unsigned IDX_W = $clog2(PACKET_BYTES);

	localparam logic [2:0] PH_HALTED    = 3'd0;
	localparam logic [2:0] PH_HANDSHAKE = 3'd1;
	localparam logic [2:0] PH_IDLE      = 3'd2;
	localparam logic [2:0] PH_HDR1      = 3'd3;
	localparam logic [2:0] PH_HDR2      = 3'd4;
	localparam logic [2:0] PH_DATA      = 3'd5;
	localparam logic [2:0] PH_CHECK     = 3'd6;

	logic [7:0]       retry_limit_q;
	logic [23:0]      max_size_q;

	logic [2:0]       phase_q,   phase_n;
	logic [7:0]       blk_q,     blk_n;
	logic [IDX_W-1:0] idx_q,     idx_n;
	logic [7:0]       sum_q,     sum_n;
	logic [24:0]      acc_q,     acc_n;
	logic [7:0]       retries_q, retries_n;
	logic [2:0]       fstat_q,   fstat_n;

	always_comb begin
		phase_n   = phase_q;
		blk_n     = blk_q;
		idx_n     = idx_q;
		sum_n     = sum_q;
		acc_n     = acc_q;
		retries_n = retries_q;
		fstat_n   = fstat_q;
		result    = '0;

		case (operation)
			xmcr_pkg::OP_START: begin
				phase_n   = PH_HANDSHAKE;
				blk_n     = '0;
				idx_n     = '0;
				sum_n     = '0;
				acc_n     = '0;
				retries_n = retry_limit_q;
				fstat_n   = xmcr_pkg::ST_RUN;
				result.tx_valid = 1'b1;
				result.tx_byte  = xmcr_pkg::C_NAK;
			end
			xmcr_pkg::OP_TIMEOUT: begin
				if (phase_q == PH_HANDSHAKE) begin
					if (retries_q != 8'd0) begin
						retries_n = retries_q - 8'd1;
						result.tx_valid = 1'b1;
						result.tx_byte  = xmcr_pkg::C_NAK;
					end else begin
						phase_n = PH_IDLE;
					end
				end else if (phase_q != PH_HALTED) begin
					phase_n = PH_HALTED;
					fstat_n = xmcr_pkg::ST_RXERR;
				end
			end
			xmcr_pkg::OP_BYTE: begin
				case (phase_q)
					PH_HANDSHAKE, PH_IDLE: begin
						phase_n = PH_IDLE;
						if (rx_byte == xmcr_pkg::C_EOT) begin
							result.tx_valid = 1'b1;
							result.tx_byte  = xmcr_pkg::C_ACK;
							phase_n = PH_HALTED;
							fstat_n = xmcr_pkg::ST_DONE;
						end else if (rx_byte == xmcr_pkg::C_CAN) begin
							result.tx_valid = 1'b1;
							result.tx_byte  = xmcr_pkg::C_ACK;
							phase_n = PH_HALTED;
							fstat_n = xmcr_pkg::ST_RCANCEL;
						end else if (rx_byte == xmcr_pkg::C_SOH) begin
							phase_n = PH_HDR1;
						end
					end
					PH_HDR1: begin
						blk_n   = rx_byte;
						phase_n = PH_HDR2;
					end
					PH_HDR2: begin
						idx_n = '0;
						sum_n = '0;
						if (blk_q == ~rx_byte) begin
							phase_n = PH_DATA;
						end else begin
							result.tx_valid = 1'b1;
							result.tx_byte  = xmcr_pkg::C_CAN;
							phase_n = PH_HALTED;
							fstat_n = xmcr_pkg::ST_HEADER;
						end
					end
					PH_DATA: begin
						result.mem_write = 1'b1;
						result.mem_addr  = acc_q[23:0] + 24'(idx_q);
						result.mem_data  = rx_byte;
						sum_n = sum_q + rx_byte;
						if (idx_q == IDX_W'(PACKET_BYTES - 1)) begin
							idx_n   = '0;
							phase_n = PH_CHECK;
						end else begin
							idx_n = idx_q + IDX_W'(1);
						end
					end
					PH_CHECK: begin
						result.tx_valid = 1'b1;
						if (rx_byte == sum_q) begin
							acc_n = acc_q + 25'(PACKET_BYTES);
							if (acc_n > {1'b0, max_size_q}) begin
								result.tx_byte = xmcr_pkg::C_CAN;
								phase_n = PH_HALTED;
								fstat_n = xmcr_pkg::ST_OOM;
							end else begin
								result.tx_byte = xmcr_pkg::C_ACK;
								phase_n = PH_IDLE;
							end
						end else begin
							result.tx_byte = xmcr_pkg::C_CAN;
							phase_n = PH_HALTED;
							fstat_n = xmcr_pkg::ST_CHECKSUM;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		result.status     = (phase_n == PH_HALTED) ? fstat_n : xmcr_pkg::ST_RUN;
		result.byte_count = acc_n;
	end

	// Advance protocol state only on an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HALTED;
			blk_q     <= '0;
			idx_q     <= '0;
			sum_q     <= '0;
			acc_q     <= '0;
			retries_q <= '0;
			fstat_q   <= xmcr_pkg::ST_RUN;
		end else if (accept) begin
			phase_q   <= phase_n;
			blk_q     <= blk_n;
			idx_q     <= idx_n;
			sum_q     <= sum_n;
			acc_q     <= acc_n;
			retries_q <= retries_n;
			fstat_q   <= fstat_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= xmcr_pkg::RETRY_LIMIT_RST;
			max_size_q    <= xmcr_pkg::MAX_SIZE_RST;
		end else if (cfg_wr.en) begin
			case (cfg_wr.index)
				xmcr_pkg::REG_RETRY_LIMIT: retry_limit_q <= cfg_wr.data[7:0];
				xmcr_pkg::REG_MAX_SIZE:    max_size_q    <= cfg_wr.data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/xmcr_out_buf.sv =====
// Result register plus a skid stage that absorbs a push while the output is stalled.
`timescale 1ns / 1ps

module xmcr_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  xmcr_pkg::result_t push_data,
	output logic              push_ready,
	output logic              pop_valid,
	input  logic              pop_ready,
	output xmcr_pkg::result_t pop_data
);

	xmcr_pkg::result_t main_q;
	xmcr_pkg::result_t skid_q;
	logic              main_valid_q;
	logic              skid_valid_q;

	assign push_ready = !skid_valid_q;
	assign pop_valid  = main_valid_q;
	assign pop_data   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop_ready) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop_ready) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== rtl/xmodem_checksum_receiver.sv =====
// Top level of the XMODEM checksum receiver.
`timescale 1ns / 1ps

// XMODEM receiver with the 8-bit additive checksum.
// Channels:
//   evt - one item per event: start, received byte, or timeout/receive error.
//   res - exactly one result item per event item: payload store request,
//         control byte to send (NAK/ACK/CAN), status and verified byte count.
//   cfg - register writes (0 retry_limit, 1 max_size); always ready. Write only
//         while the block is idle.
// Each result item is registered: into the output register, or the skid while res stalls.
// Throughput: one item per cycle while evt.ready is high; next-state logic is
// combinational, so every event follows the previous one directly.
// Stall: a two-entry result buffer (output register plus skid) holds results
// while res is stalled; evt.ready drops only when both entries are full.
// Reset: the protocol halts with status running and zero count, result buffer
// empties, and retry_limit/max_size return to 16 and 16777088. Only a start
// event leaves the halted state.
module xmodem_checksum_receiver #(
	parameter int unsigned PACKET_BYTES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	xmcr_evt_if.sink   evt,
	xmcr_res_if.source res,
	xmcr_cfg_if.sink   cfg
);

	logic              accept;
	logic              buf_ready;
	xmcr_pkg::cfg_wr_t cfg_wr;
	xmcr_pkg::result_t core_result;
	xmcr_pkg::result_t out_result;

	// Take an event whenever the skid entry is free
	assign evt.ready = buf_ready;
	assign accept    = evt.valid && buf_ready;

	// Registers take a write in any cycle
	assign cfg.ready    = 1'b1;
	assign cfg_wr.en    = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	xmcr_core #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (evt.operation),
		.rx_byte   (evt.rx_byte),
		.cfg_wr    (cfg_wr),
		.result    (core_result)
	);

	xmcr_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (core_result),
		.push_ready (buf_ready),
		.pop_valid  (res.valid),
		.pop_ready  (res.ready),
		.pop_data   (out_result)
	);

	// Drive the result fields from the buffer head
	assign res.mem_write  = out_result.mem_write;
	assign res.mem_addr   = out_result.mem_addr;
	assign res.mem_data   = out_result.mem_data;
	assign res.tx_valid   = out_result.tx_valid;
	assign res.tx_byte    = out_result.tx_byte;
	assign res.status     = out_result.status;
	assign res.byte_count = out_result.byte_count;

	// A payload store never coincides with a control byte to send
	a_store_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.mem_write |-> !res.tx_valid)
		else $error("store and control byte in one result");

	// A control byte is always NAK, ACK or CAN
	a_tx_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.tx_valid |-> (res.tx_byte == xmcr_pkg::C_NAK ||
			res.tx_byte == xmcr_pkg::C_ACK || res.tx_byte == xmcr_pkg::C_CAN))
		else $error("bad control byte");

	// Stores happen only while the transfer runs
	a_store_running: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.mem_write |-> res.status == xmcr_pkg::ST_RUN)
		else $error("store after end of transfer");

	// Input stalls only when a result waits at the output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> res.valid)
		else $error("input stalled with empty output");

endmodule
